[rtl/core/pixel_blend_modes_top_assert.svh]
// assertion macros for the pixel blend pipeline
// no dependencies; included by pixel_blend_modes_top
`ifndef PIXEL_BLEND_MODES_TOP_ASSERT_SVH
`define PIXEL_BLEND_MODES_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PBM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pbm assertion failed");
`define PBM_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("pbm forbidden condition seen");
`else
`define PBM_ASSERT(lbl, clk, rstn, prop)
`define PBM_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

[rtl/core/pbm_pkg.sv]
// shared types and constants of the pixel blend pipeline
// no dependencies
package pbm_pkg;

  localparam int CHANNEL_BITS_DEF = 8;
  localparam int NUM_CH           = 4;

  typedef enum logic [3:0] {
    MODE_NORMAL  = 4'd0,
    MODE_ADD     = 4'd1,
    MODE_SUB     = 4'd2,
    MODE_MUL     = 4'd3,
    MODE_DIV     = 4'd4,
    MODE_SCREEN  = 4'd5,
    MODE_OVERLAY = 4'd6,
    MODE_DODGE   = 4'd7,
    MODE_BURN    = 4'd8,
    MODE_DIFF    = 4'd9,
    MODE_DARKEN  = 4'd10,
    MODE_LIGHTEN = 4'd11,
    MODE_TRANSP  = 4'd12
  } mode_e;

  // whole-pixel overrides decided from the blend mode and the top pixel alone
  typedef enum logic [2:0] {
    SP_NONE,
    SP_ZERO,
    SP_FULL,
    SP_KEEP,
    SP_KEY
  } spec_e;

  typedef struct packed {
    logic [3:0] mode;
    spec_e      spec;
  } ctl_t;

endpackage

[rtl/core/pixel_blend_modes_top.sv]
// channel           | dir | payload
// s_axis            | in  | bottom rgba, top rgba (tdata, low bits first)
// m_axis            | out | blended rgba (tdata, low bits first)
// cfg_we/cfg_wdata  | in  | blend select register write
//
// one pixel per clock while m_axis does not stall; a pixel passes pbm_front, the
// restoring divider chain that takes one quotient bit per stage, and pbm_back
// reset clears the blend mode to normal and empties the pipeline
// a stall on m_axis holds every stage; s_axis_tready drops in the same cycle
// depends on pbm_pkg, pbm_front, pbm_div_step, pbm_back and the assertion header
module pixel_blend_modes_top #(
  parameter int CHANNEL_BITS = pbm_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       cfg_we_i,
  input  logic [3:0]                                 cfg_wdata_i,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // bottom_red, bottom_green, bottom_blue, bottom_alpha,
  // top_red, top_green, top_blue, top_alpha
  input  logic [8*CHANNEL_BITS-1:0]                  s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // out_red, out_green, out_blue, out_alpha, zero fill to whole bytes
  output logic [((4*CHANNEL_BITS+7)/8)*8-1:0]        m_axis_tdata
);
  import pbm_pkg::*;

  `include "pixel_blend_modes_top_assert.svh"

  localparam int W        = CHANNEL_BITS;
  localparam int OUT_BITS = ((4*CHANNEL_BITS+7)/8)*8;

  logic [3:0]                        mode_sel_q;
  logic                              en;
  logic [NUM_CH-1:0][W-1:0]          bot_in, top_in, pix;

  logic [W:0]                        v_s;
  ctl_t [W:0]                        ctl_s;
  logic [W:0][NUM_CH-1:0][W-1:0]     bot_s, top_s, den_s, rem_s, quo_s;
  logic [W:0][NUM_CH-1:0][2*W:0]     prod_s;
  logic [W:0][NUM_CH-1:0]            ceil_s, sat_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_sel_q <= MODE_NORMAL;
    end else if (cfg_we_i) begin
      mode_sel_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      bot_in[c] = s_axis_tdata[c*W +: W];
      top_in[c] = s_axis_tdata[(c+NUM_CH)*W +: W];
    end
  end

  // whole pipeline advances together while the output register can move
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  pbm_front #(.CHANNEL_BITS(CHANNEL_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .mode_i  (mode_sel_q),
    .bot_i   (bot_in),
    .top_i   (top_in),
    .valid_o (v_s[0]),
    .ctl_o   (ctl_s[0]),
    .bot_o   (bot_s[0]),
    .top_o   (top_s[0]),
    .den_o   (den_s[0]),
    .rem_o   (rem_s[0]),
    .quo_o   (quo_s[0]),
    .prod_o  (prod_s[0]),
    .ceil_o  (ceil_s[0]),
    .sat_o   (sat_s[0])
  );

  for (genvar i = 0; i < W; i++) begin : g_div
    pbm_div_step #(.CHANNEL_BITS(CHANNEL_BITS)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_s[i]),
      .ctl_i   (ctl_s[i]),
      .bot_i   (bot_s[i]),
      .top_i   (top_s[i]),
      .den_i   (den_s[i]),
      .rem_i   (rem_s[i]),
      .quo_i   (quo_s[i]),
      .prod_i  (prod_s[i]),
      .ceil_i  (ceil_s[i]),
      .sat_i   (sat_s[i]),
      .valid_o (v_s[i+1]),
      .ctl_o   (ctl_s[i+1]),
      .bot_o   (bot_s[i+1]),
      .top_o   (top_s[i+1]),
      .den_o   (den_s[i+1]),
      .rem_o   (rem_s[i+1]),
      .quo_o   (quo_s[i+1]),
      .prod_o  (prod_s[i+1]),
      .ceil_o  (ceil_s[i+1]),
      .sat_o   (sat_s[i+1])
    );
  end

  pbm_back #(.CHANNEL_BITS(CHANNEL_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_s[W]),
    .ctl_i   (ctl_s[W]),
    .bot_i   (bot_s[W]),
    .top_i   (top_s[W]),
    .rem_i   (rem_s[W]),
    .quo_i   (quo_s[W]),
    .prod_i  (prod_s[W]),
    .ceil_i  (ceil_s[W]),
    .sat_i   (sat_s[W]),
    .valid_o (m_axis_tvalid),
    .pix_o   (pix)
  );

  assign m_axis_tdata = OUT_BITS'(pix);

  `PBM_ASSERT(a_accept_enters, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> v_s[0])
  `PBM_ASSERT(a_key_spec, clk_i, rst_ni, (v_s[0] && (ctl_s[0].mode == MODE_TRANSP)) |-> ((ctl_s[0].spec == SP_KEEP) || (ctl_s[0].spec == SP_KEY)))
  `PBM_ASSERT_NEVER(a_rem_below_den, clk_i, rst_ni, v_s[W] && !sat_s[W][0] && (rem_s[W][0] >= den_s[W][0]))

endmodule

[rtl/core/pbm_front.sv]
// first pipeline stage: operand select, channel products, divider setup
// depends on pbm_pkg
module pbm_front #(
  parameter int CHANNEL_BITS = pbm_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          valid_i,
  input  logic [3:0]                                    mode_i,
  input  logic [pbm_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]  bot_i,
  input  logic [pbm_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]  top_i,
  output logic                                          valid_o,
  output pbm_pkg::ctl_t                                 ctl_o,
  output logic [pbm_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]  bot_o,
  output logic [pbm_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]  top_o,
  output logic [pbm_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]  den_o,
  output logic [pbm_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]  rem_o,
  output logic [pbm_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]  quo_o,
  output logic [pbm_pkg::NUM_CH-1:0][2*CHANNEL_BITS:0]  prod_o,
  output logic [pbm_pkg::NUM_CH-1:0]                    ceil_o,
  output logic [pbm_pkg::NUM_CH-1:0]                    sat_o
);
  import pbm_pkg::*;

  localparam int W = CHANNEL_BITS;
  localparam int unsigned MAXI = (1 << W) - 1;
  localparam logic [W-1:0] MAXV   = W'(MAXI);
  localparam logic [W-1:0] KEY_TH = W'(MAXI / 5);

  logic                             valid_q;
  ctl_t                             ctl_q, ctl_d;
  logic [NUM_CH-1:0][W-1:0]         bot_q, top_q, den_q, rem_q, quo_q;
  logic [NUM_CH-1:0][W-1:0]         den_d, rem_d, quo_d, opa, opc, num;
  logic [NUM_CH-1:0][2*W-1:0]       mp, nfull;
  logic [NUM_CH-1:0][2*W:0]         prod_q, prod_d;
  logic [NUM_CH-1:0]                ceil_q, ceil_d, sat_q, sat_d;
  logic                             top_zero, top_full, key_keep;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      // overlay upper half and screen work on the inverted channels
      ceil_d[c] = (mode_i == MODE_SCREEN) ||
                  ((mode_i == MODE_OVERLAY) && bot_i[c][W-1]);
      opa[c]    = ceil_d[c] ? ~bot_i[c] : bot_i[c];
      opc[c]    = ceil_d[c] ? ~top_i[c] : top_i[c];
      mp[c]     = (2*W)'(opa[c]) * (2*W)'(opc[c]);
      prod_d[c] = (mode_i == MODE_OVERLAY) ? {mp[c], 1'b0} : {1'b0, mp[c]};
      num[c]    = (mode_i == MODE_BURN)  ? ~bot_i[c] : bot_i[c];
      den_d[c]  = (mode_i == MODE_DODGE) ? ~top_i[c] : top_i[c];
      // quotient of num*max/den reaches max once num >= den
      sat_d[c]  = num[c] >= den_d[c];
      nfull[c]  = {num[c], W'(0)} - (2*W)'(num[c]);
      rem_d[c]  = nfull[c][2*W-1:W];
      quo_d[c]  = nfull[c][W-1:0];
    end
    top_zero = (top_i[0] == '0) && (top_i[1] == '0) && (top_i[2] == '0);
    top_full = (top_i[0] == MAXV) && (top_i[1] == MAXV) && (top_i[2] == MAXV);
    key_keep = (top_i[3] == MAXV) &&
               ({top_i[0], top_i[1], top_i[2]} > {KEY_TH, KEY_TH, KEY_TH});
    ctl_d.mode = mode_i;
    if (mode_i == MODE_TRANSP) begin
      ctl_d.spec = key_keep ? SP_KEEP : SP_KEY;
    end else if ((mode_i == MODE_DIV) && top_zero) begin
      ctl_d.spec = SP_ZERO;
    end else if ((mode_i == MODE_BURN) && top_zero) begin
      ctl_d.spec = SP_FULL;
    end else if ((mode_i == MODE_DODGE) && top_full) begin
      ctl_d.spec = SP_ZERO;
    end else begin
      ctl_d.spec = SP_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q  <= ctl_d;
      bot_q  <= bot_i;
      top_q  <= top_i;
      den_q  <= den_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      prod_q <= prod_d;
      ceil_q <= ceil_d;
      sat_q  <= sat_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign bot_o   = bot_q;
  assign top_o   = top_q;
  assign den_o   = den_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign prod_o  = prod_q;
  assign ceil_o  = ceil_q;
  assign sat_o   = sat_q;

endmodule

[rtl/core/pbm_div_step.sv]
// one restoring division step for all four channels, plus carried payload
// depends on pbm_pkg
module pbm_div_step #(
  parameter int CHANNEL_BITS = pbm_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          valid_i,
  input  pbm_pkg::ctl_t                                 ctl_i,
  input  logic [pbm_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]  bot_i,
  input  logic [pbm_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]  top_i,
  input  logic [pbm_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]  den_i,
  input  logic [pbm_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]  rem_i,
  input  logic [pbm_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]  quo_i,
  input  logic [pbm_pkg::NUM_CH-1:0][2*CHANNEL_BITS:0]  prod_i,
  input  logic [pbm_pkg::NUM_CH-1:0]                    ceil_i,
  input  logic [pbm_pkg::NUM_CH-1:0]                    sat_i,
  output logic                                          valid_o,
  output pbm_pkg::ctl_t                                 ctl_o,
  output logic [pbm_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]  bot_o,
  output logic [pbm_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]  top_o,
  output logic [pbm_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]  den_o,
  output logic [pbm_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]  rem_o,
  output logic [pbm_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]  quo_o,
  output logic [pbm_pkg::NUM_CH-1:0][2*CHANNEL_BITS:0]  prod_o,
  output logic [pbm_pkg::NUM_CH-1:0]                    ceil_o,
  output logic [pbm_pkg::NUM_CH-1:0]                    sat_o
);
  import pbm_pkg::*;

  localparam int W = CHANNEL_BITS;

  logic                      valid_q;
  ctl_t                      ctl_q;
  logic [NUM_CH-1:0][W-1:0]  bot_q, top_q, den_q, rem_q, quo_q, rem_d, quo_d;
  logic [NUM_CH-1:0][2*W:0]  prod_q;
  logic [NUM_CH-1:0]         ceil_q, sat_q, ge;
  logic [NUM_CH-1:0][W:0]    trial, diff;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      // shift the next dividend bit into the partial remainder
      trial[c] = {rem_i[c], quo_i[c][W-1]};
      diff[c]  = trial[c] - {1'b0, den_i[c]};
      ge[c]    = trial[c] >= {1'b0, den_i[c]};
      rem_d[c] = ge[c] ? diff[c][W-1:0] : trial[c][W-1:0];
      quo_d[c] = {quo_i[c][W-2:0], ge[c]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q  <= ctl_i;
      bot_q  <= bot_i;
      top_q  <= top_i;
      den_q  <= den_i;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      prod_q <= prod_i;
      ceil_q <= ceil_i;
      sat_q  <= sat_i;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign bot_o   = bot_q;
  assign top_o   = top_q;
  assign den_o   = den_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign prod_o  = prod_q;
  assign ceil_o  = ceil_q;
  assign sat_o   = sat_q;

endmodule

[rtl/core/pbm_back.sv]
// last two stages: product reduction by the channel max, mode select, output register
// depends on pbm_pkg
module pbm_back #(
  parameter int CHANNEL_BITS = pbm_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          en_i,
  input  logic                                          valid_i,
  input  pbm_pkg::ctl_t                                 ctl_i,
  input  logic [pbm_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]  bot_i,
  input  logic [pbm_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]  top_i,
  input  logic [pbm_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]  rem_i,
  input  logic [pbm_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]  quo_i,
  input  logic [pbm_pkg::NUM_CH-1:0][2*CHANNEL_BITS:0]  prod_i,
  input  logic [pbm_pkg::NUM_CH-1:0]                    ceil_i,
  input  logic [pbm_pkg::NUM_CH-1:0]                    sat_i,
  output logic                                          valid_o,
  output logic [pbm_pkg::NUM_CH-1:0][CHANNEL_BITS-1:0]  pix_o
);
  import pbm_pkg::*;

  localparam int W = CHANNEL_BITS;
  localparam logic [W-1:0] MAXV = '1;
  localparam logic [W-1:0] HALF = MAXV >> 1;

  // reduce stage
  logic [NUM_CH-1:0][W:0]    q0;
  logic [NUM_CH-1:0][W+1:0]  r0, qf, qv_d;
  logic [NUM_CH-1:0][1:0]    q1;
  logic [NUM_CH-1:0][W:0]    r1;
  logic [NUM_CH-1:0]         fix, rnz, dnz_d;

  logic                      valid_q;
  ctl_t                      ctl_q;
  logic [NUM_CH-1:0][W-1:0]  bot_q, top_q, quo_q;
  logic [NUM_CH-1:0][W+1:0]  qv_q;
  logic [NUM_CH-1:0]         dnz_q, sat_q;

  // output stage
  logic [NUM_CH-1:0][W-1:0]  blend, pix_d, pix_q;
  logic [NUM_CH-1:0][W:0]    sum;
  logic                      out_valid_q;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      // x / max as x = hi*2^W + lo = hi*max + (hi + lo), folded twice
      q0[c]    = prod_i[c][2*W:W];
      r0[c]    = (W+2)'(prod_i[c][W-1:0]) + (W+2)'(q0[c]);
      q1[c]    = r0[c][W+1:W];
      r1[c]    = (W+1)'(r0[c][W-1:0]) + (W+1)'(q1[c]);
      fix[c]   = r1[c] >= (W+1)'(MAXV);
      rnz[c]   = fix[c] ? (r1[c] != (W+1)'(MAXV)) : (r1[c] != '0);
      qf[c]    = (W+2)'(q0[c]) + (W+2)'(q1[c]) + (W+2)'(fix[c]);
      qv_d[c]  = qf[c] + (W+2)'(ceil_i[c] & rnz[c]);
      dnz_d[c] = rem_i[c] != '0;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      sum[c] = (W+1)'(bot_q[c]) + (W+1)'(top_q[c]);
      unique case (ctl_q.mode)
        MODE_ADD:     blend[c] = sum[c][W] ? MAXV : sum[c][W-1:0];
        MODE_SUB:     blend[c] = (bot_q[c] > top_q[c]) ? bot_q[c] - top_q[c] : '0;
        MODE_MUL:     blend[c] = qv_q[c][W-1:0];
        MODE_DIV,
        MODE_DODGE:   blend[c] = sat_q[c] ? MAXV : quo_q[c];
        MODE_SCREEN:  blend[c] = MAXV - qv_q[c][W-1:0];
        MODE_OVERLAY: begin
          if (!bot_q[c][W-1]) begin
            blend[c] = (qv_q[c] > (W+2)'(MAXV)) ? MAXV : qv_q[c][W-1:0];
          end else begin
            blend[c] = (qv_q[c] > (W+2)'(MAXV)) ? '0 : MAXV - qv_q[c][W-1:0];
          end
        end
        MODE_BURN:    blend[c] = sat_q[c] ? '0 : MAXV - quo_q[c] - W'(dnz_q[c]);
        MODE_DIFF:    blend[c] = (bot_q[c] > top_q[c]) ? bot_q[c] - top_q[c]
                                                       : top_q[c] - bot_q[c];
        MODE_DARKEN:  blend[c] = (bot_q[c] < top_q[c]) ? bot_q[c] : top_q[c];
        MODE_LIGHTEN: blend[c] = (bot_q[c] > top_q[c]) ? bot_q[c] : top_q[c];
        default:      blend[c] = top_q[c];
      endcase
    end
    unique case (ctl_q.spec)
      SP_ZERO: pix_d = '0;
      SP_FULL: pix_d = '1;
      SP_KEEP: pix_d = bot_q;
      SP_KEY:  pix_d = {HALF, W'(0), W'(0), W'(0)};
      default: pix_d = blend;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q     <= valid_i;
      out_valid_q <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q <= ctl_i;
      bot_q <= bot_i;
      top_q <= top_i;
      quo_q <= quo_i;
      qv_q  <= qv_d;
      dnz_q <= dnz_d;
      sat_q <= sat_i;
      pix_q <= pix_d;
    end
  end

  assign valid_o = out_valid_q;
  assign pix_o   = pix_q;

endmodule
